// ===== sv/ialu_pkg.sv =====
// ialu_pkg: opcodes, request and result structs, and the divider side-band
// record for the pipelined integer ALU. No dependencies.

package ialu_pkg;

  // Fixed field widths of the request and result
  localparam int WORD_W = 64;
  localparam int CMD_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_SDIV = 5'd3,
    OP_UDIV = 5'd4,
    OP_SMOD = 5'd5,
    OP_UMOD = 5'd6,
    OP_AND  = 5'd7,
    OP_OR   = 5'd8,
    OP_XOR  = 5'd9,
    OP_SHL  = 5'd10,
    OP_SHR  = 5'd11,
    OP_SAR  = 5'd12,
    OP_EQ   = 5'd13,
    OP_NE   = 5'd14,
    OP_LT   = 5'd15,
    OP_GT   = 5'd16,
    OP_LE   = 5'd17,
    OP_GE   = 5'd18,
    OP_NEG  = 5'd19,
    OP_ABS  = 5'd20,
    OP_NOT  = 5'd21
  } opcode_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
  } ialu_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              divide_by_zero;
  } ialu_out_t;

  // Travels with each request through the divider array
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] res;    // result of every non-divide op
    logic [WORD_W-1:0] a;      // dividend as given, for zero divisor
    logic              aneg;
    logic              bneg;
    logic              bzero;
  } ialu_tag_t;

endpackage

// ===== sv/ialu_div.sv =====
// ialu_div: unsigned restoring divider, one quotient bit per pipeline stage.
// Depends on ialu_pkg for the side-band record.

module ialu_div #(
  parameter int W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [W-1:0]       dividend,
  input  logic [W-1:0]       divisor,
  input  ialu_pkg::ialu_tag_t in_tag,
  output logic               out_valid,
  output logic [W-1:0]       quotient,
  output logic [W-1:0]       remainder,
  output ialu_pkg::ialu_tag_t out_tag
);
  import ialu_pkg::*;

  // stage k holds the partial remainder after k quotient bits
  logic             v_r   [W+1];
  logic [W-1:0]     rem_r [W+1];
  logic [W-1:0]     quo_r [W+1];
  logic [W-1:0]     dsr_r [W+1];
  ialu_tag_t        tag_r [W+1];

  logic             v_nxt   [W+1];
  logic [W-1:0]     rem_nxt [W+1];
  logic [W-1:0]     quo_nxt [W+1];
  logic [W-1:0]     dsr_nxt [W+1];
  ialu_tag_t        tag_nxt [W+1];

  logic [W:0]       trial [W];
  logic [W:0]       diff  [W];
  logic             ge    [W];

  // one trial subtract per stage
  always_comb begin
    v_nxt[0]   = in_valid;
    rem_nxt[0] = '0;
    quo_nxt[0] = dividend;
    dsr_nxt[0] = divisor;
    tag_nxt[0] = in_tag;
    for (int k = 0; k < W; k++) begin
      trial[k] = {rem_r[k], quo_r[k][W-1]};
      diff[k]  = trial[k] - {1'b0, dsr_r[k]};
      ge[k]    = trial[k] >= {1'b0, dsr_r[k]};
      v_nxt[k+1]   = v_r[k];
      rem_nxt[k+1] = ge[k] ? diff[k][W-1:0] : trial[k][W-1:0];
      quo_nxt[k+1] = {quo_r[k][W-2:0], ge[k]};
      dsr_nxt[k+1] = dsr_r[k];
      tag_nxt[k+1] = tag_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= W; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_nxt[k];
      end
      rem_r[k] <= rem_nxt[k];
      quo_r[k] <= quo_nxt[k];
      dsr_r[k] <= dsr_nxt[k];
      tag_r[k] <= tag_nxt[k];
    end
  end

  assign out_valid = v_r[W];
  assign quotient  = quo_r[W];
  assign remainder = rem_r[W];
  assign out_tag   = tag_r[W];

endmodule

// ===== sv/integer_alu_fold.sv =====
// integer_alu_fold: fully pipelined integer ALU, top level.
// Depends on ialu_pkg and ialu_div.

// Takes one request per clock and never asserts busy. Each result appears on
// out_rsp with out_valid high for exactly one cycle; the receiver must take it
// then. The depth is set by the divider array, which resolves one quotient
// bit per stage; every operation runs through the same pipeline so results
// leave in request order. Division or modulo by zero returns all ones
// (quotient) or the dividend (remainder) and raises divide_by_zero. Compares
// are unsigned. Operands are cut to DATA_WIDTH bits and results are
// zero-extended.

module integer_alu_fold #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ialu_pkg::ialu_in_t  in_req,
  output logic                out_valid,
  output ialu_pkg::ialu_out_t out_rsp
);
  import ialu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int SW = $clog2(W);
  localparam int L  = W / 2;
  localparam int H  = W - L;
  localparam logic [W-1:0] SH_LIM = W'(W);

  assign busy = 1'b0;

  // stage 1: capture request, cut to W bits
  logic             s1_v_r;
  logic [CMD_W-1:0] s1_cmd_r;
  logic [W-1:0]     s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start;
    end
    s1_cmd_r <= in_req.cmd;
    s1_a_r   <= in_req.operand_a[W-1:0];
    s1_b_r   <= in_req.operand_b[W-1:0];
  end

  // stage 2: simple ops, magnitudes, partial products
  logic         aneg, bneg, sgn_op, big_sh, flag;
  logic [W-1:0] mag_a, mag_b, res2, sum, dif;
  logic [SW-1:0] sh;
  logic [L-1:0] al, bl;
  logic [H-1:0] ah, bh;
  logic [2*L-1:0] pp_ll;
  logic [L+H-1:0] pp_x1, pp_x2;

  always_comb begin
    aneg   = s1_a_r[W-1];
    bneg   = s1_b_r[W-1];
    mag_a  = aneg ? (~s1_a_r + W'(1)) : s1_a_r;
    mag_b  = bneg ? (~s1_b_r + W'(1)) : s1_b_r;
    sgn_op = (s1_cmd_r == OP_SDIV) || (s1_cmd_r == OP_SMOD);
    sh     = s1_b_r[SW-1:0];
    big_sh = s1_b_r >= SH_LIM;
    sum    = s1_a_r + s1_b_r;
    dif    = s1_a_r - s1_b_r;
    flag   = 1'b0;
    res2   = '0;
    case (s1_cmd_r)
      OP_ADD: res2 = sum;
      OP_SUB: res2 = dif;
      OP_AND: res2 = s1_a_r & s1_b_r;
      OP_OR:  res2 = s1_a_r | s1_b_r;
      OP_XOR: res2 = s1_a_r ^ s1_b_r;
      OP_SHL: res2 = big_sh ? '0 : (s1_a_r << sh);
      OP_SHR: res2 = big_sh ? '0 : (s1_a_r >> sh);
      OP_SAR: begin
        if (big_sh) begin
          res2 = {W{aneg}};
        end else begin
          res2 = W'($signed(s1_a_r) >>> sh);
        end
      end
      OP_EQ: flag = s1_a_r == s1_b_r;
      OP_NE: flag = s1_a_r != s1_b_r;
      OP_LT: flag = s1_a_r <  s1_b_r;
      OP_GT: flag = s1_a_r >  s1_b_r;
      OP_LE: flag = s1_a_r <= s1_b_r;
      OP_GE: flag = s1_a_r >= s1_b_r;
      OP_NEG: res2 = ~s1_a_r + W'(1);
      OP_ABS: res2 = mag_a;
      OP_NOT: res2 = ~s1_a_r;
      default: res2 = '0;
    endcase
    if ((s1_cmd_r == OP_EQ) || (s1_cmd_r == OP_NE) || (s1_cmd_r == OP_LT) ||
        (s1_cmd_r == OP_GT) || (s1_cmd_r == OP_LE) || (s1_cmd_r == OP_GE)) begin
      res2 = W'(flag);
    end
    // product mod 2^W from three half-width products
    al    = s1_a_r[L-1:0];
    ah    = s1_a_r[W-1:L];
    bl    = s1_b_r[L-1:0];
    bh    = s1_b_r[W-1:L];
    pp_ll = al * bl;
    pp_x1 = al * bh;
    pp_x2 = ah * bl;
  end

  logic             s2_v_r, s2_aneg_r, s2_bneg_r, s2_bzero_r;
  logic [CMD_W-1:0] s2_cmd_r;
  logic [W-1:0]     s2_res_r, s2_a_r, s2_dvd_r, s2_dsr_r;
  logic [2*L-1:0]   s2_pp_ll_r;
  logic [H-1:0]     s2_pp_x1_r, s2_pp_x2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_cmd_r   <= s1_cmd_r;
    s2_res_r   <= res2;
    s2_a_r     <= s1_a_r;
    s2_aneg_r  <= aneg;
    s2_bneg_r  <= bneg;
    s2_bzero_r <= s1_b_r == '0;
    s2_dvd_r   <= sgn_op ? mag_a : s1_a_r;
    s2_dsr_r   <= sgn_op ? mag_b : s1_b_r;
    s2_pp_ll_r <= pp_ll;
    s2_pp_x1_r <= pp_x1[H-1:0];
    s2_pp_x2_r <= pp_x2[H-1:0];
  end

  // stage 3: finish multiply, build side-band, enter divider
  logic [H-1:0] xsum;
  logic [W-1:0] mul_res, res3;
  ialu_tag_t    tag3;

  always_comb begin
    xsum    = s2_pp_x1_r + s2_pp_x2_r;
    mul_res = {xsum, {L{1'b0}}} + W'(s2_pp_ll_r);
    res3    = (s2_cmd_r == OP_MUL) ? mul_res : s2_res_r;
    tag3.cmd   = s2_cmd_r;
    tag3.res   = WORD_W'(res3);
    tag3.a     = WORD_W'(s2_a_r);
    tag3.aneg  = s2_aneg_r;
    tag3.bneg  = s2_bneg_r;
    tag3.bzero = s2_bzero_r;
  end

  logic         dv_v;
  logic [W-1:0] dv_q, dv_r;
  ialu_tag_t    dv_tag;

  ialu_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .dividend  (s2_dvd_r),
    .divisor   (s2_dsr_r),
    .in_tag    (tag3),
    .out_valid (dv_v),
    .quotient  (dv_q),
    .remainder (dv_r),
    .out_tag   (dv_tag)
  );

  // final stage: sign fix, zero-divisor override, result select
  logic [W-1:0] q_fix, r_fix, res_f;
  logic         dz_f, div_op, mod_op;

  always_comb begin
    div_op = (dv_tag.cmd == OP_SDIV) || (dv_tag.cmd == OP_UDIV);
    mod_op = (dv_tag.cmd == OP_SMOD) || (dv_tag.cmd == OP_UMOD);
    q_fix  = ((dv_tag.cmd == OP_SDIV) && (dv_tag.aneg != dv_tag.bneg)) ?
             (~dv_q + W'(1)) : dv_q;
    r_fix  = ((dv_tag.cmd == OP_SMOD) && dv_tag.aneg) ? (~dv_r + W'(1)) : dv_r;
    dz_f   = (div_op || mod_op) && dv_tag.bzero;
    if (div_op) begin
      res_f = dv_tag.bzero ? '1 : q_fix;
    end else if (mod_op) begin
      res_f = dv_tag.bzero ? dv_tag.a[W-1:0] : r_fix;
    end else begin
      res_f = dv_tag.res[W-1:0];
    end
  end

  logic      out_v_r;
  ialu_out_t out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_v;
    end
    out_rsp_r.result         <= WORD_W'(res_f);
    out_rsp_r.divide_by_zero <= dz_f;
  end

  assign out_valid = out_v_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for the pipelined integer ALU.
// Depends on ialu_pkg and integer_alu_fold; drives random and directed requests.
`timescale 1ns / 100ps

module tb_top;
  import ialu_pkg::*;

  localparam int W = 64;
  localparam int LATENCY = W + 4;
  localparam int WDOG_LIMIT = 20 * LATENCY + 2000;

  // Scoreboard: predicts each request's result and checks arrivals in order
  class alu_scoreboard;
    ialu_out_t pending[$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    function ialu_out_t compute(ialu_in_t rq);
      ialu_out_t o;
      logic [W-1:0] a, b, ma, mb, r;
      logic aneg, bneg;
      a = rq.operand_a;
      b = rq.operand_b;
      aneg = a[W-1];
      bneg = b[W-1];
      ma = aneg ? -a : a;
      mb = bneg ? -b : b;
      r = '0;
      o.divide_by_zero = 1'b0;
      case (rq.cmd)
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_MUL: r = a * b;
        OP_SDIV: begin
          if (b == 0) begin
            r = '1;
            o.divide_by_zero = 1'b1;
          end else begin
            r = ma / mb;
            if (aneg != bneg) r = -r;
          end
        end
        OP_UDIV: begin
          if (b == 0) begin
            r = '1;
            o.divide_by_zero = 1'b1;
          end else r = a / b;
        end
        OP_SMOD: begin
          if (b == 0) begin
            r = a;
            o.divide_by_zero = 1'b1;
          end else begin
            r = ma % mb;
            if (aneg) r = -r;
          end
        end
        OP_UMOD: begin
          if (b == 0) begin
            r = a;
            o.divide_by_zero = 1'b1;
          end else r = a % b;
        end
        OP_AND: r = a & b;
        OP_OR:  r = a | b;
        OP_XOR: r = a ^ b;
        OP_SHL: r = (b >= W) ? '0 : a << b;
        OP_SHR: r = (b >= W) ? '0 : a >> b;
        OP_SAR: r = (b >= W) ? {W{aneg}} : $unsigned($signed(a) >>> b[6:0]);
        OP_EQ:  r = W'(a == b);
        OP_NE:  r = W'(a != b);
        OP_LT:  r = W'(a < b);
        OP_GT:  r = W'(a > b);
        OP_LE:  r = W'(a <= b);
        OP_GE:  r = W'(a >= b);
        OP_NEG: r = -a;
        OP_ABS: r = ma;
        OP_NOT: r = ~a;
        default: r = '0;
      endcase
      o.result = r;
      return o;
    endfunction

    function void note_request(ialu_in_t rq);
      pending.push_back(compute(rq));
    endfunction

    function void check_result(ialu_out_t got);
      ialu_out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h / %b", $time, got.result, got.divide_by_zero);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.result !== exp.result) begin
        $display("%0t: result expected %h actual %h", $time, exp.result, got.result);
        errors++;
      end
      if (got.divide_by_zero !== exp.divide_by_zero) begin
        $display("%0t: divide_by_zero expected %b actual %b", $time,
                 exp.divide_by_zero, got.divide_by_zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ialu_in_t in_req = '0;
  logic out_valid;
  ialu_out_t out_rsp;

  alu_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;

  always #2 clk = ~clk;

  integer_alu_fold #(.DATA_WIDTH(W)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_request(in_req);
        sent++;
      end
      if (out_valid) sb.check_result(out_rsp);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Present one request, hold until accepted; start stays high afterward
  task automatic send_request(input logic [4:0] cmd, input logic [W-1:0] a,
                              input logic [W-1:0] b);
    in_req.cmd <= cmd;
    in_req.operand_a <= a;
    in_req.operand_b <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [W-1:0] rand_word();
    logic [W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = {1'b1, {(W-1){1'b0}}};
      3: v = {1'b0, {(W-1){1'b1}}};
      4: v = W'($urandom_range(0, 9));
      5: v = -W'($urandom_range(1, 9));
      default: ;
    endcase
    return v;
  endfunction

  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  initial begin
    logic [4:0] op;
    logic [W-1:0] a, b;
    int burst;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero divisors, signed overflow, big shifts, abs of minimum
    send_request(OP_ADD, '1, 1);
    send_request(OP_SUB, 0, 1);
    send_request(OP_MUL, '1, '1);
    send_request(OP_SDIV, 7, 0);
    send_request(OP_UDIV, 7, 0);
    send_request(OP_SMOD, '1, 0);
    send_request(OP_UMOD, MINV, 0);
    send_request(OP_SDIV, MINV, '1);
    send_request(OP_SMOD, MINV, '1);
    send_request(OP_SDIV, -W'(7), 2);
    send_request(OP_SMOD, -W'(7), 2);
    send_request(OP_SHL, 1, 63);
    send_request(OP_SHL, 1, 64);
    send_request(OP_SHR, '1, 64);
    send_request(OP_SAR, MINV, 64);
    send_request(OP_SAR, MINV, 0);
    send_request(OP_SAR, MINV, 5);
    send_request(OP_SHR, '1, '1);
    send_request(OP_ABS, MINV, 0);
    send_request(OP_NEG, 0, 0);
    send_request(OP_NOT, 0, '1);
    send_request(OP_LT, 0, '1);
    send_request(OP_GE, '1, '1);
    send_request(5'd22, '1, '1);
    send_request(5'd31, '1, '1);

    // Drain fully once before the random part
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);

    // Random bursts with random gaps
    while (sent < 630) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(22, 31))
                                          : 5'($urandom_range(0, 21));
        a = rand_word();
        b = rand_word();
        if ((op == OP_SHL || op == OP_SHR || op == OP_SAR) && $urandom_range(0, 2) != 0)
          b = W'($urandom_range(0, 70));
        send_request(op, a, b);
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    $display("sent %0d requests, checked %0d results over all opcodes,",
             sent, sb.checked);
    $display("including zero divisors, signed overflow and out-of-range shifts");
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
